// File: hdl/fepp_pkg.sv
// ----------------------------------------------------------------------------
// fepp_pkg
// Shared constants and codes for the flash erase / program planner.
// ----------------------------------------------------------------------------
package fepp_pkg;

  // Flash geometry, all powers of two
  localparam int unsigned PAGE_BYTES   = 256;
  localparam int unsigned SECTOR_BYTES = 4096;
  localparam int unsigned BLOCK_BYTES  = 65536;
  localparam int unsigned FLASH_SPACE  = 32'h0100_0000;

  // Field widths
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned ADDR_W  = 24;
  localparam int unsigned LEN_W   = 25;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned COUNT_W = 9;
  localparam int unsigned ERR_W   = 2;
  localparam int unsigned MAXP_W  = 13;

  localparam logic [MAXP_W-1:0] MAX_PROGRAM_RESET = 13'd4096;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_NEXT        = 2'd0;
  localparam logic [CMD_W-1:0] CMD_START_ERASE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PROGRAM     = 2'd2;

  // Operation kinds
  localparam logic [KIND_W-1:0] OP_NONE   = 2'd0;
  localparam logic [KIND_W-1:0] OP_SECTOR = 2'd1;
  localparam logic [KIND_W-1:0] OP_BLOCK  = 2'd2;
  localparam logic [KIND_W-1:0] OP_PAGE   = 2'd3;

  // Error codes
  localparam logic [ERR_W-1:0] ERR_OK        = 2'd0;
  localparam logic [ERR_W-1:0] ERR_LEN_RANGE = 2'd1;
  localparam logic [ERR_W-1:0] ERR_NO_JOB    = 2'd2;

endpackage

// File: hdl/fepp_if.sv
// ----------------------------------------------------------------------------
// fepp channel interfaces
// Valid/ready channels for job words, operation words and the config write.
// ----------------------------------------------------------------------------
interface fepp_item_if
  import fepp_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [ADDR_W-1:0] address;
  logic [LEN_W-1:0]  length;

  modport source (output valid, output cmd, output address, output length, input ready);
  modport sink   (input valid, input cmd, input address, input length, output ready);
endinterface

interface fepp_result_if
  import fepp_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  op_kind;
  logic [ADDR_W-1:0]  op_address;
  logic [COUNT_W-1:0] byte_count;
  logic [LEN_W-1:0]   progress;
  logic               last_op;
  logic [ERR_W-1:0]   error;

  modport source (output valid, output op_kind, output op_address, output byte_count,
                  output progress, output last_op, output error, input ready);
  modport sink   (input valid, input op_kind, input op_address, input byte_count,
                  input progress, input last_op, input error, output ready);
endinterface

interface fepp_cfg_if
  import fepp_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [MAXP_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/flash_erase_program_planner.sv
// ----------------------------------------------------------------------------
// flash_erase_program_planner
// Splits flash erase and program jobs into SPI NOR operations.
// ----------------------------------------------------------------------------
// Usage:
//   item   : job words (cmd, address, length). A start-erase or start-program
//            word opens a job and yields its first operation; a next word
//            yields the following operation. Every word gives one result.
//   result : operation words (op_kind, op_address, byte_count, progress,
//            last_op, error). last_op marks the final operation of a job.
//   cfg    : writes max_program_length; always ready. Write only while idle.
// An accepted item passes through one input register, then the planning
// logic (one add, mask and compare on the job position) feeding the result
// register. One word is accepted per cycle while results are taken.
// When the receiver stalls, the result register holds, the input register
// fills, and item.ready drops until the result is taken; no word is lost.
// Reset empties both registers, drops any pending job and sets
// max_program_length to 4096.
// ----------------------------------------------------------------------------
module flash_erase_program_planner
  import fepp_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  fepp_item_if.sink     item,
  fepp_result_if.source result,
  fepp_cfg_if.sink      cfg
);

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_ERASE   = 2'd1,
    MODE_PROGRAM = 2'd2
  } mode_t;

  localparam logic [LEN_W-1:0] SECTOR_MASK = LEN_W'(SECTOR_BYTES - 1);
  localparam logic [LEN_W-1:0] BLOCK_MASK  = LEN_W'(BLOCK_BYTES - 1);
  localparam logic [LEN_W-1:0] PAGE_MASK   = LEN_W'(PAGE_BYTES - 1);
  localparam logic [LEN_W-1:0] SECTOR_SIZE = LEN_W'(SECTOR_BYTES);
  localparam logic [LEN_W-1:0] BLOCK_SIZE  = LEN_W'(BLOCK_BYTES);
  localparam logic [LEN_W-1:0] PAGE_SIZE   = LEN_W'(PAGE_BYTES);
  localparam logic [LEN_W:0]   SPACE_END   = (LEN_W+1)'(FLASH_SPACE);

  // Config register
  logic [MAXP_W-1:0] max_program_length;

  // Job state
  mode_t             job_mode, job_mode_next;
  logic [LEN_W-1:0]  position, position_next;
  logic [LEN_W-1:0]  end_position, end_position_next;

  // Input register
  logic              s1_valid;
  logic [CMD_W-1:0]  s1_cmd;
  logic [ADDR_W-1:0] s1_address;
  logic [LEN_W-1:0]  s1_length;

  // Result register contents
  logic               out_valid;
  logic [KIND_W-1:0]  out_kind,  kind_next;
  logic [ADDR_W-1:0]  out_addr,  addr_next;
  logic [COUNT_W-1:0] out_count, count_next;
  logic [LEN_W-1:0]   out_prog,  prog_next;
  logic               out_last,  last_next;
  logic [ERR_W-1:0]   out_err,   err_next;

  logic out_advance;
  logic s1_fire;

  // Handshake: result register frees when empty or taken
  assign out_advance = !out_valid || result.ready;
  assign s1_fire     = s1_valid && out_advance;
  assign item.ready  = !s1_valid || out_advance;
  assign cfg.ready   = 1'b1;

  assign result.valid      = out_valid;
  assign result.op_kind    = out_kind;
  assign result.op_address = out_addr;
  assign result.byte_count = out_count;
  assign result.progress   = out_prog;
  assign result.last_op    = out_last;
  assign result.error      = out_err;

  // Planning logic
  logic [LEN_W:0]   finish;
  logic             bad_length;
  mode_t            work_mode;
  logic [LEN_W-1:0] work_pos;
  logic [LEN_W-1:0] work_end;
  logic [LEN_W-1:0] remain;
  logic [LEN_W-1:0] room;
  logic [LEN_W-1:0] step;
  logic [LEN_W-1:0] pos_after;
  logic             is_last;
  logic [KIND_W-1:0] emit_kind;
  logic             emit_ok;

  always_comb begin
    finish     = {2'b00, s1_address} + {1'b0, s1_length};
    bad_length = (s1_length == '0) || (finish > SPACE_END) ||
                 ((s1_cmd == CMD_PROGRAM) &&
                  (s1_length > {{(LEN_W-MAXP_W){1'b0}}, max_program_length}));

    // Pick the job to advance: a fresh start or the stored one
    work_mode = job_mode;
    work_pos  = position;
    work_end  = end_position;
    if (s1_cmd == CMD_START_ERASE) begin
      work_mode = MODE_ERASE;
      work_pos  = {1'b0, s1_address} & ~SECTOR_MASK;
      work_end  = LEN_W'(finish + (LEN_W+1)'(SECTOR_BYTES - 1)) & ~SECTOR_MASK;
    end else if (s1_cmd == CMD_PROGRAM) begin
      work_mode = MODE_PROGRAM;
      work_pos  = {1'b0, s1_address};
      work_end  = LEN_W'(finish);
    end

    // Size the next operation
    remain = work_end - work_pos;
    room   = PAGE_SIZE - (work_pos & PAGE_MASK);
    if (work_mode == MODE_ERASE) begin
      if (((work_pos & BLOCK_MASK) == '0) && (remain >= BLOCK_SIZE)) begin
        emit_kind = OP_BLOCK;
        step      = BLOCK_SIZE;
      end else begin
        emit_kind = OP_SECTOR;
        step      = SECTOR_SIZE;
      end
    end else begin
      emit_kind = OP_PAGE;
      step      = (room < remain) ? room : remain;
    end
    pos_after = work_pos + step;
    is_last   = (pos_after >= work_end);

    // Defaults: empty result, state held
    kind_next         = OP_NONE;
    addr_next         = '0;
    count_next        = '0;
    prog_next         = '0;
    last_next         = 1'b0;
    err_next          = ERR_OK;
    job_mode_next     = job_mode;
    position_next     = position;
    end_position_next = end_position;
    emit_ok           = 1'b0;

    case (s1_cmd)
      CMD_NEXT: begin
        if (job_mode == MODE_IDLE) begin
          err_next = ERR_NO_JOB;
        end else begin
          emit_ok = 1'b1;
        end
      end
      CMD_START_ERASE, CMD_PROGRAM: begin
        if (bad_length) begin
          err_next      = ERR_LEN_RANGE;
          job_mode_next = MODE_IDLE;
        end else begin
          emit_ok = 1'b1;
        end
      end
      default: begin
      end
    endcase

    // Emit the operation and advance the job
    if (emit_ok) begin
      kind_next         = emit_kind;
      addr_next         = work_pos[ADDR_W-1:0];
      count_next        = (emit_kind == OP_PAGE) ? step[COUNT_W-1:0] : '0;
      prog_next         = pos_after;
      last_next         = is_last;
      job_mode_next     = is_last ? MODE_IDLE : work_mode;
      position_next     = pos_after;
      end_position_next = work_end;
    end
  end

  // Input register: load on accept, drop when passed on
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.valid && item.ready) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
    if (item.valid && item.ready) begin
      s1_cmd     <= item.cmd;
      s1_address <= item.address;
      s1_length  <= item.length;
    end
  end

  // Result register and job state
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      job_mode     <= MODE_IDLE;
      position     <= '0;
      end_position <= '0;
    end else begin
      if (s1_fire) begin
        out_valid    <= 1'b1;
        job_mode     <= job_mode_next;
        position     <= position_next;
        end_position <= end_position_next;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
    if (s1_fire) begin
      out_kind  <= kind_next;
      out_addr  <= addr_next;
      out_count <= count_next;
      out_prog  <= prog_next;
      out_last  <= last_next;
      out_err   <= err_next;
    end
  end

  // Config register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_program_length <= MAX_PROGRAM_RESET;
    end else if (cfg.valid && cfg.ready) begin
      max_program_length <= cfg.data;
    end
  end

endmodule
